>>> sv/fsd_pkg.sv
// Shared types, constants and helpers for the RGB error-diffusion dither.
`default_nettype none

package fsd_pkg;

    localparam int CFG_W = 11;
    localparam int IDX_W = 1;
    localparam int CH_N  = 3;
    localparam int PIX_W = 8;
    localparam int ERR_W = 8;
    localparam int WORD_W = CH_N * ERR_W;

    localparam logic [IDX_W-1:0] REG_WIDTH  = 1'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

    // diffusion weights, in sixteenths
    localparam logic [2:0] WT_RIGHT      = 3'd7;
    localparam logic [2:0] WT_BELOW_LEFT = 3'd3;
    localparam logic [2:0] WT_BELOW      = 3'd5;
    localparam logic [2:0] WT_BELOW_RT   = 3'd1;

    typedef logic signed [ERR_W-1:0] err_t;
    typedef logic signed [8:0]       qerr_t;

    typedef struct packed {
        logic on;
        err_t right;
        err_t done_left;
        err_t below_left;
        err_t below_here;
    } lane_res_t;

    // e * w / 16 with truncation toward zero
    function automatic err_t frac16(input qerr_t e, input logic [2:0] w);
        logic signed [12:0] p;
        logic signed [12:0] q;
        p = 13'(e) * $signed({10'b0, w});
        if (p < 0)
            q = (p + 13'sd15) >>> 4;
        else
            q = p >>> 4;
        return q[ERR_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/floyd_steinberg_rgb_dither.sv
// Top level of the RGB error-diffusion dither: framing, line buffer, lanes, output.
// Usage:
//   Input channel (in_valid/in_stall, red/green/blue) takes one RGB pixel per
//   request in raster order. Output channel (out_valid/out_stall, red_on,
//   green_on, blue_on, row_end, frame_end) returns one dithered pixel per
//   request, in the same order.
//   Throughput: one pixel per clock while the output is not stalled. The
//   running error state (right carry, below sums) feeds back in each lane.
//   Path: the input request is registered with the line buffer read, then
//   the lane compute is registered into the output register.
//   A stalled output holds; the input keeps accepting while the compute stage
//   is free, so one pixel can sit behind a waiting result.
//   Reset clears position, carries and handshake state; width and height
//   return to 640 x 480. The line buffer is not cleared: row 0 never reads it.
//   Registers (cfg_we/cfg_index/cfg_data): index 0 width, 1 height; write
//   only while the block is idle. Zero counts as 1, values above the maximum
//   count as the maximum.
`default_nettype none

module floyd_steinberg_rgb_dither #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [fsd_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [fsd_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [fsd_pkg::PIX_W-1:0]   red,
    input  wire logic [fsd_pkg::PIX_W-1:0]   green,
    input  wire logic [fsd_pkg::PIX_W-1:0]   blue,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             red_on,
    output logic                             green_on,
    output logic                             blue_on,
    output logic                             row_end,
    output logic                             frame_end
);
    import fsd_pkg::*;

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WDW = (XW + 1 > CFG_W) ? XW + 1 : CFG_W;
    localparam int HDW = (YW + 1 > CFG_W) ? YW + 1 : CFG_W;

    // configuration
    logic [CFG_W-1:0] width_reg, height_reg;
    logic [WDW-1:0]   w_eff;
    logic [HDW-1:0]   h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WDW'(1);
        else if (WDW'(width_reg) > WDW'(MAX_WIDTH))
            w_eff = WDW'(MAX_WIDTH);
        else
            w_eff = WDW'(width_reg);
        if (height_reg == '0)
            h_eff = HDW'(1);
        else if (HDW'(height_reg) > HDW'(MAX_HEIGHT))
            h_eff = HDW'(MAX_HEIGHT);
        else
            h_eff = HDW'(height_reg);
    end

    // handshake
    logic s1_valid_reg, out_valid_reg;
    logic move, accept;

    assign move     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !move;
    assign accept   = in_valid && !in_stall;

    // frame position at the input side
    logic [XW-1:0] col_reg;
    logic [YW-1:0] row_reg;
    logic          acc_last_col, acc_last_row;

    assign acc_last_col = (WDW'(col_reg) + WDW'(1)) >= w_eff;
    assign acc_last_row = (HDW'(row_reg) + HDW'(1)) >= h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (acc_last_col)
            begin
                col_reg <= '0;
                row_reg <= acc_last_row ? '0 : row_reg + YW'(1);
            end
            else
                col_reg <= col_reg + XW'(1);
        end
    end

    // stage 1: pixel plus line buffer read
    logic [PIX_W-1:0]  s1_pix_reg [CH_N];
    logic [XW-1:0]     s1_x_reg;
    logic              s1_top_row_reg;
    logic              s1_last_col_reg, s1_last_row_reg;
    logic              s1_fwd_reg;
    logic [WORD_W-1:0] s1_fwd_data_reg;

    // lane results and merge
    err_t              carry_reg      [CH_N];
    err_t              below_left_reg [CH_N];
    err_t              below_here_reg [CH_N];
    lane_res_t         res            [CH_N];
    logic [WORD_W-1:0] rd_word, above_word, done_left_word, below_left_word;

    // line buffer writes: direct (column left) and deferred (last column)
    logic              dir_we, pend_set;
    logic [XW-1:0]     dir_addr;
    logic              pend_valid_reg;
    logic [XW-1:0]     pend_addr_reg;
    logic [WORD_W-1:0] pend_data_reg;
    logic              mem_we;
    logic [XW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    assign dir_we    = move && !s1_last_row_reg && (s1_x_reg != '0);
    assign dir_addr  = s1_x_reg - XW'(1);
    assign pend_set  = move && !s1_last_row_reg && s1_last_col_reg;
    assign mem_we    = dir_we || pend_valid_reg;
    assign mem_waddr = dir_we ? dir_addr : pend_addr_reg;
    assign mem_wdata = dir_we ? done_left_word : pend_data_reg;

    fsd_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (XW)
    ) u_line_buf (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (rd_word)
    );

    // forward line buffer writes the registered read would miss, newest first
    logic              fwd_hit;
    logic [WORD_W-1:0] fwd_data;

    always_comb
    begin
        fwd_hit  = 1'b1;
        fwd_data = pend_data_reg;
        priority if (dir_we && dir_addr == col_reg)
            fwd_data = done_left_word;
        else if (pend_set && s1_x_reg == col_reg)
            fwd_data = below_left_word;
        else if (pend_valid_reg && pend_addr_reg == col_reg)
            fwd_data = pend_data_reg;
        else
            fwd_hit = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (move)
                s1_valid_reg <= 1'b0;
            pend_valid_reg <= pend_set;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg[0]   <= red;
            s1_pix_reg[1]   <= green;
            s1_pix_reg[2]   <= blue;
            s1_x_reg        <= col_reg;
            s1_top_row_reg  <= (row_reg == '0);
            s1_last_col_reg <= acc_last_col;
            s1_last_row_reg <= acc_last_row;
            s1_fwd_reg      <= fwd_hit;
            s1_fwd_data_reg <= fwd_data;
        end
        if (pend_set)
        begin
            pend_addr_reg <= s1_x_reg;
            pend_data_reg <= below_left_word;
        end
    end

    // row 0 takes no error from above
    always_comb
    begin
        if (s1_top_row_reg)
            above_word = '0;
        else if (s1_fwd_reg)
            above_word = s1_fwd_data_reg;
        else
            above_word = rd_word;
    end

    for (genvar c = 0; c < CH_N; c++)
    begin : g_lane
        fsd_lane u_lane (
            .pix            (s1_pix_reg[c]),
            .carry          (carry_reg[c]),
            .above          (above_word[c*ERR_W +: ERR_W]),
            .below_left_sum (below_left_reg[c]),
            .below_here_sum (below_here_reg[c]),
            .last_col       (s1_last_col_reg),
            .res            (res[c])
        );
        assign done_left_word[c*ERR_W +: ERR_W]  = res[c].done_left;
        assign below_left_word[c*ERR_W +: ERR_W] = res[c].below_left;
    end

    // running error state along the row; cleared at each row end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CH_N; c++)
            begin
                carry_reg[c]      <= '0;
                below_left_reg[c] <= '0;
                below_here_reg[c] <= '0;
            end
        end
        else if (move)
        begin
            for (int c = 0; c < CH_N; c++)
            begin
                carry_reg[c]      <= res[c].right;
                below_left_reg[c] <= s1_last_col_reg ? '0 : res[c].below_left;
                below_here_reg[c] <= res[c].below_here;
            end
        end
    end

    // output register
    logic red_on_reg, green_on_reg, blue_on_reg, row_end_reg, frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (move)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            red_on_reg    <= res[0].on;
            green_on_reg  <= res[1].on;
            blue_on_reg   <= res[2].on;
            row_end_reg   <= s1_last_col_reg;
            frame_end_reg <= s1_last_col_reg && s1_last_row_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_on    = red_on_reg;
    assign green_on  = green_on_reg;
    assign blue_on   = blue_on_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

    // the deferred write never meets a direct write
    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(pend_valid_reg && dir_we))
        else $error("line buffer write port clash");

    // a last-column pixel off the last row always leaves a deferred write to its column
    a_pend_source: assert property (@(posedge clk) disable iff (!rst_n)
        pend_set |=> pend_valid_reg && (pend_addr_reg == $past(s1_x_reg)))
        else $error("deferred write lost");

    // frame end is always a row end
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_end_reg) |-> row_end_reg)
        else $error("frame end without row end");

    // row end pixels leave the red lane's running carries cleared
    a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (move && s1_last_col_reg) |=> (carry_reg[0] == '0) && (below_here_reg[0] == '0))
        else $error("row carries not cleared");

endmodule

`default_nettype wire

>>> sv/fsd_lane.sv
// One color channel: add diffused error, clamp, threshold, split the error.
`default_nettype none

module fsd_lane (
    input  wire logic [fsd_pkg::PIX_W-1:0] pix,
    input  wire fsd_pkg::err_t             carry,
    input  wire fsd_pkg::err_t             above,
    input  wire fsd_pkg::err_t             below_left_sum,
    input  wire fsd_pkg::err_t             below_here_sum,
    input  wire logic                      last_col,
    output fsd_pkg::lane_res_t             res
);
    import fsd_pkg::*;

    logic signed [9:0] sum;
    logic [PIX_W-1:0]  level;
    qerr_t             e;

    always_comb
    begin
        sum = $signed({2'b0, pix}) + 10'(carry) + 10'(above);
        if (sum < 0)
            level = '0;
        else if (sum > 10'sd255)
            level = '1;
        else
            level = sum[PIX_W-1:0];
        res.on = level[PIX_W-1];
        if (res.on)
            e = $signed({1'b0, level}) - 9'sd255;
        else
            e = $signed({1'b0, level});
        res.right      = last_col ? '0 : frac16(e, WT_RIGHT);
        res.done_left  = below_left_sum + frac16(e, WT_BELOW_LEFT);
        res.below_left = below_here_sum + frac16(e, WT_BELOW);
        res.below_here = last_col ? '0 : frac16(e, WT_BELOW_RT);
    end

endmodule

`default_nettype wire

>>> sv/fsd_line_buf.sv
// Next-row error line buffer: one write port, one registered read port.
`default_nettype none

module fsd_line_buf #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [AW-1:0]              waddr,
    input  wire logic [fsd_pkg::WORD_W-1:0] wdata,
    input  wire logic                       re,
    input  wire logic [AW-1:0]              raddr,
    output logic      [fsd_pkg::WORD_W-1:0] rdata
);
    import fsd_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the RGB error-diffusion dither: random stimulus, predictor compare.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fsd_pkg::*;

    localparam int MAX_W = 1024;
    localparam int MAX_H = 1024;
    localparam int SETTLE_CYCLES = 4;     // two-stage pipe plus margin
    localparam int QUIET_LIMIT = 2000;    // cycles with no transfer on either side
    localparam int RANDOM_PIXELS = 220;
    localparam int TALL_ROWS = 40;        // one-pixel rows before the height shrinks

    // pixel content styles for random frames
    typedef enum int {
        STYLE_UNIFORM,
        STYLE_NEAR_MID,
        STYLE_RAILS,
        STYLE_FLAT
    } pixel_style_t;

    typedef struct packed {
        logic red_on;
        logic green_on;
        logic blue_on;
        logic row_end;
        logic frame_end;
    } dither_dot_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = REG_WIDTH;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [PIX_W-1:0] red = '0;
    logic [PIX_W-1:0] green = '0;
    logic [PIX_W-1:0] blue = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic red_on;
    logic green_on;
    logic blue_on;
    logic row_end;
    logic frame_end;

    floyd_steinberg_rgb_dither dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_on    (red_on),
        .green_on  (green_on),
        .blue_on   (blue_on),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: raw register values, error line buffer, carries and
    // raster position, all as the block is expected to hold them.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] frame_w = WIDTH_RESET;
    logic [CFG_W-1:0] frame_h = HEIGHT_RESET;
    err_t line_err [MAX_W][3];
    err_t carry_err [3] = '{default: '0};
    err_t left_sum [3] = '{default: '0};
    err_t here_sum [3] = '{default: '0};
    int unsigned pos_x = 0;
    int unsigned pos_y = 0;

    dither_dot_t dithered_q [$];   // dithered pixels still owed by the block
    int mismatches = 0;
    int pixels_sent = 0;
    bit frame_closed = 1'b0;       // last pixel sent ended its frame
    bit steady = 1'b0;             // no idling on either side while set
    int quiet_cycles = 0;
    dither_dot_t want;

    // zero reads as 1, anything past the maximum reads as the maximum
    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] raw,
                                            input int unsigned top);
        if (raw == 0)
            return 1;
        if (raw > top)
            return top;
        return raw;
    endfunction

    // One pixel through the diffusion; updates predictor state.
    function automatic dither_dot_t dither_pixel(input logic [7:0] r,
                                                 input logic [7:0] g,
                                                 input logic [7:0] b);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        bit last_col;
        bit last_row;
        int v;
        int e;
        int pix [3];
        bit lit [3];
        err_t above;
        err_t next_carry [3];
        err_t next_left [3];
        err_t next_here [3];
        dither_dot_t dot;
        w = eff_dim(frame_w, MAX_W);
        h = eff_dim(frame_h, MAX_H);
        x = pos_x;
        y = pos_y;
        last_col = (x + 1 >= w);
        last_row = (y + 1 >= h);
        pix[0] = r;
        pix[1] = g;
        pix[2] = b;
        for (int c = 0; c < 3; c++)
        begin
            // row 0 never looks at the line buffer
            above = (y > 0 && x < MAX_W) ? line_err[x][c] : err_t'(0);
            v = pix[c] + int'(carry_err[c]) + int'(above);
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            lit[c] = (v >= 128);
            e = v - (lit[c] ? 255 : 0);
            // integer divide truncates toward zero
            next_carry[c] = last_col ? err_t'(0) : err_t'(e * 7 / 16);
            next_left[c] = err_t'(int'(here_sum[c]) + e * 5 / 16);
            next_here[c] = last_col ? err_t'(0) : err_t'(e / 16);
            if (!last_row)
            begin
                if (x >= 1)
                    line_err[x-1][c] = err_t'(int'(left_sum[c]) + e * 3 / 16);
                if (last_col && x < MAX_W)
                    line_err[x][c] = next_left[c];
            end
        end
        dot.red_on = lit[0];
        dot.green_on = lit[1];
        dot.blue_on = lit[2];
        dot.row_end = last_col;
        dot.frame_end = last_col && last_row;
        if (last_col)
        begin
            carry_err = '{default: '0};
            left_sum = '{default: '0};
            here_sum = '{default: '0};
            pos_x = 0;
            pos_y = last_row ? 0 : y + 1;
        end
        else
        begin
            carry_err = next_carry;
            left_sum = next_left;
            here_sum = next_here;
            pos_x = x + 1;
        end
        return dot;
    endfunction

    // ------------------------------------------------------------------
    // Request side. Valid stays up across back-to-back pixels; it only
    // drops when the sender idles or drains.
    // ------------------------------------------------------------------
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        dither_dot_t dot;
        while (!steady && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        red <= r;
        green <= g;
        blue <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        dot = dither_pixel(r, g, b);
        dithered_q.push_back(dot);
        frame_closed = dot.frame_end;
        pixels_sent++;
    endtask

    // hold off until every result is back, then let the pipe settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (dithered_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // registers only change with the block idle
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_WIDTH)
            frame_w = val;
        else
            frame_h = val;
    endtask

    function automatic logic [7:0] channel_value(input pixel_style_t style,
                                                 input logic [7:0] flat);
        case (style)
            STYLE_NEAR_MID: return 8'($urandom_range(144, 112));
            STYLE_RAILS: return $urandom_range(1) ? 8'($urandom_range(255, 250))
                                                  : 8'($urandom_range(5));
            STYLE_FLAT: return flat;
            default: return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Power-on geometry is 640 x 480; push a few rail and threshold values.
    task automatic test_power_on_size();
        send_pixel(8'd255, 8'd0, 8'd128);
        send_pixel(8'd0, 8'd255, 8'd127);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd127, 8'd127, 8'd127);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
    endtask

    // Shrink width while sitting at column 6: that pixel closes the row.
    // Then shrink height on row 1 so it becomes the last row.
    task automatic test_shrink_mid_frame();
        write_reg(REG_WIDTH, 11'd3);
        send_pixel(8'd200, 8'd60, 8'd130);
        write_reg(REG_HEIGHT, 11'd2);
        send_pixel(8'd10, 8'd250, 8'd129);
        send_pixel(8'd128, 8'd0, 8'd255);
        send_pixel(8'd90, 8'd170, 8'd126);
    endtask

    // Zero width and height both count as one: every pixel ends a frame.
    task automatic test_degenerate_sizes();
        write_reg(REG_WIDTH, '0);
        write_reg(REG_HEIGHT, '0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd128, 8'd127, 8'd200);
    endtask

    // 4 x 3 frame of rail and threshold values to drive the sums into clamping.
    task automatic test_saturation_corners();
        logic [7:0] ramp [12];
        ramp = '{8'd255, 8'd254, 8'd129, 8'd128, 8'd127, 8'd1,
                 8'd0, 8'd0, 8'd255, 8'd128, 8'd127, 8'd255};
        write_reg(REG_WIDTH, 11'd4);
        write_reg(REG_HEIGHT, 11'd3);
        for (int i = 0; i < 12; i++)
            send_pixel(ramp[i], ramp[11-i], ramp[(i*5) % 12]);
    endtask

    // Mostly small random frames; some get a register shrunk partway in.
    task automatic test_random_frames();
        int start;
        int shrink_at;
        int n;
        pixel_style_t style;
        logic [7:0] flat;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS)
        begin
            case ($urandom_range(19))
                0: write_reg(REG_WIDTH, '0);
                1, 2, 3, 4: write_reg(REG_WIDTH, 11'($urandom_range(64, 13)));
                default: write_reg(REG_WIDTH, 11'($urandom_range(12, 1)));
            endcase
            write_reg(REG_HEIGHT, ($urandom_range(9) == 0) ? '0
                                                          : 11'($urandom_range(8, 1)));
            style = pixel_style_t'($urandom_range(3));
            flat = 8'($urandom);
            shrink_at = ($urandom_range(4) == 0)
                ? $urandom_range(eff_dim(frame_w, MAX_W) * eff_dim(frame_h, MAX_H) - 1)
                : -1;
            n = 0;
            do
            begin
                if (n == shrink_at && n != 0)
                begin
                    // only shrink mid-frame: growing could read stale line buffer
                    if ($urandom_range(1))
                        write_reg(REG_WIDTH, 11'($urandom_range(eff_dim(frame_w, MAX_W), 1)));
                    else
                        write_reg(REG_HEIGHT, 11'($urandom_range(eff_dim(frame_h, MAX_H), 1)));
                end
                send_pixel(channel_value(style, flat), channel_value(style, flat),
                           channel_value(style, flat));
                n++;
            end
            while (!frame_closed);
        end
    endtask

    // Oversized width clamps to the full line buffer; one row, no idling.
    task automatic test_widest_rows();
        write_reg(REG_WIDTH, '1);
        write_reg(REG_HEIGHT, 11'd1);
        steady = 1'b1;
        do
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        while (!frame_closed);
        steady = 1'b0;
    endtask

    // Oversized height counts as the maximum row count: a run of one-pixel
    // rows never ends the frame, then a smaller height closes it at once.
    task automatic test_tallest_frame();
        write_reg(REG_WIDTH, 11'd1);
        write_reg(REG_HEIGHT, '1);
        repeat (TALL_ROWS)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        write_reg(REG_HEIGHT, 11'd16);
        do
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        while (!frame_closed);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_power_on_size();
        test_shrink_mid_frame();
        test_degenerate_sizes();
        test_saturation_corners();
        test_random_frames();
        test_widest_rows();
        test_tallest_frame();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && dithered_q.size() == 0)
            $display("floyd_steinberg_rgb_dither regression: pass");
        else
            $display("floyd_steinberg_rgb_dither regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stall, then compare each accepted pixel.
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(99) < 34);

    function automatic void compare_field(input string field, input logic exp_bit,
                                          input logic got_bit);
        if (got_bit !== exp_bit)
        begin
            $display("%0t: %s mismatch, expected %0b, actual %0b",
                     $time, field, exp_bit, got_bit);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (dithered_q.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, actual %b",
                         $time, {red_on, green_on, blue_on, row_end, frame_end});
                mismatches++;
            end
            else
            begin
                want = dithered_q.pop_front();
                compare_field("red_on", want.red_on, red_on);
                compare_field("green_on", want.green_on, green_on);
                compare_field("blue_on", want.blue_on, blue_on);
                compare_field("row_end", want.row_end, row_end);
                compare_field("frame_end", want.frame_end, frame_end);
            end
        end
    end

    // watchdog: too long without a transfer on either side ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("floyd_steinberg_rgb_dither regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

`default_nettype wire

>>> filelist.f
sv/fsd_pkg.sv
sv/fsd_lane.sv
sv/fsd_line_buf.sv
sv/floyd_steinberg_rgb_dither.sv
tb/tb.sv
